[hdl/gre_pkg.sv]
// Shared types, widths, register codes and the root table for the gamma ramp generator.
package gre_pkg;

  localparam int ENTRIES_W = 13;
  localparam int SET_W     = 16;
  localparam int X_W       = 17;
  localparam int MANT_W    = 31;
  localparam int MSB_W     = 5;
  localparam int LFRAC_W   = 16;
  localparam int NL_W      = 21;
  localparam int POW_W     = 17;
  localparam int ROOT_W    = 30;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_RAMP_ENTRIES     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CONTRAST_GAIN    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS_LEVEL = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAMMA_VALUE      = 2'd3;

  localparam logic [ENTRIES_W-1:0] RAMP_ENTRIES_RST = 13'd256;
  localparam logic [SET_W-1:0]     UNITY_Q4_12_RST  = 16'd4096;

  typedef struct packed {
    logic oor;
    logic zero;
  } flags_t;

  // 2^(-2^-k) in Q.30, built from a chain of truncated integer square roots.
  function automatic logic [ROOT_W-1:0] root_q30(input int unsigned k);
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    r = 64'd1 << 29;
    for (int unsigned j = 1; j <= 16; j++) begin
      if (j <= k) begin
        v     = r << 30;
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        for (int b = 0; b < 32; b++) begin
          if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
          end else begin
            res = res >> 1;
          end
          bit_v = bit_v >> 2;
        end
        r = res;
      end
    end
    return r[ROOT_W-1:0];
  endfunction

endpackage

[hdl/gre_in_if.sv]
// Input channel carrying one ramp entry index per transfer.
interface gre_in_if #(
  parameter int INDEX_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] entry_index;

  modport source (output valid, output entry_index, input ready);
  modport sink (input valid, input entry_index, output ready);
endinterface

[hdl/gre_out_if.sv]
// Output channel carrying one ramp level per transfer.
interface gre_out_if #(
  parameter int INDEX_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [15:0]           level;
  logic [INDEX_BITS-1:0] index_echo;
  logic                  index_out_of_range;

  modport source (output valid, output level, output index_echo, output index_out_of_range,
                  input ready);
  modport sink (input valid, input level, input index_echo, input index_out_of_range,
                output ready);
endinterface

[hdl/gamma_ramp_entry_generator.sv]
// Top level of the gamma ramp entry generator with its configuration registers.
//
// Each transfer on entry_i names one ramp entry i; one transfer on result_o returns its
// 16-bit level (shared by red, green and blue), the index and an out-of-range flag.
// The level is contrast * (i/(N-1))^(1/gamma) + brightness - 1, clamped to [0,1] and
// scaled by 65535. An index above N-1 returns level 0 with the flag set.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); write it only
// while no entry is in flight.
// Throughput is one entry per cycle unless the receiver stalls the pipeline. The stages
// are 17 for the index divider, 17 for the logarithm, 21 + FRAC_BITS for the gamma
// divider (one quotient bit per stage), 17 for the exponential and 3 for the contrast,
// offset and scaling.
// The whole pipeline advances on one enable; when the receiver holds ready low with a
// result waiting, every stage holds and entry_i.ready drops, so nothing is lost or
// repeated. While the output register is empty the pipeline keeps moving whatever the
// receiver does; bubbles travel along with the entries and are not squeezed out.
// Reset clears all valid bits and loads N = 256 and unity contrast, brightness and gamma.
module gamma_ramp_entry_generator #(
  parameter int INDEX_BITS = 12,
  parameter int FRAC_BITS  = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gre_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gre_pkg::SET_W-1:0]         cfg_data_i,
  gre_in_if.sink                            entry_i,
  gre_out_if.source                         result_o
);

  localparam int CW = (INDEX_BITS > gre_pkg::ENTRIES_W) ? INDEX_BITS : gre_pkg::ENTRIES_W;

  logic [gre_pkg::ENTRIES_W-1:0] entries_q;
  logic [gre_pkg::SET_W-1:0]     contrast_q;
  logic [gre_pkg::SET_W-1:0]     bright_q;
  logic [gre_pkg::SET_W-1:0]     gamma_q;

  // Register writes; software must write them only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q  <= gre_pkg::RAMP_ENTRIES_RST;
      contrast_q <= gre_pkg::UNITY_Q4_12_RST;
      bright_q   <= gre_pkg::UNITY_Q4_12_RST;
      gamma_q    <= gre_pkg::UNITY_Q4_12_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gre_pkg::REG_RAMP_ENTRIES:     entries_q  <= cfg_data_i[gre_pkg::ENTRIES_W-1:0];
        gre_pkg::REG_CONTRAST_GAIN:    contrast_q <= cfg_data_i;
        gre_pkg::REG_BRIGHTNESS_LEVEL: bright_q   <= cfg_data_i;
        gre_pkg::REG_GAMMA_VALUE:      gamma_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A ramp shorter than two entries is treated as two, and a zero gamma as one LSB.
  logic [gre_pkg::ENTRIES_W-1:0] last;
  logic [gre_pkg::SET_W-1:0]     gamma_div;
  assign last      = (entries_q < gre_pkg::ENTRIES_W'(2)) ? gre_pkg::ENTRIES_W'(1)
                                                          : entries_q - gre_pkg::ENTRIES_W'(1);
  assign gamma_div = (gamma_q == '0) ? gre_pkg::SET_W'(1) : gamma_q;

  // One enable for every stage: move whenever the output register is free or being drained.
  logic en;
  logic out_valid;
  assign en            = !out_valid || result_o.ready;
  assign entry_i.ready = en;

  gre_pkg::flags_t in_flags;
  assign in_flags.oor  = CW'(entry_i.entry_index) > CW'(last);
  assign in_flags.zero = entry_i.entry_index == '0;

  logic                          xd_valid, lg_valid, ed_valid, ex_valid;
  logic [INDEX_BITS-1:0]         xd_idx, lg_idx, ed_idx, ex_idx;
  gre_pkg::flags_t               xd_flags, lg_flags, ed_flags, ex_flags;
  logic [gre_pkg::X_W-1:0]       x;
  logic [gre_pkg::NL_W-1:0]      nl;
  logic [gre_pkg::NL_W+FRAC_BITS-1:0] e;
  logic [gre_pkg::POW_W-1:0]     power;

  gre_xdiv #(.INDEX_BITS(INDEX_BITS)) u_xdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (entry_i.valid),
    .idx_i   (entry_i.entry_index),
    .flags_i (in_flags),
    .last_i  (last),
    .valid_o (xd_valid),
    .idx_o   (xd_idx),
    .flags_o (xd_flags),
    .x_o     (x)
  );

  gre_log #(.INDEX_BITS(INDEX_BITS)) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (xd_valid),
    .idx_i   (xd_idx),
    .flags_i (xd_flags),
    .x_i     (x),
    .valid_o (lg_valid),
    .idx_o   (lg_idx),
    .flags_o (lg_flags),
    .nl_o    (nl)
  );

  gre_ediv #(.INDEX_BITS(INDEX_BITS), .FRAC_BITS(FRAC_BITS)) u_ediv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lg_valid),
    .idx_i   (lg_idx),
    .flags_i (lg_flags),
    .nl_i    (nl),
    .gamma_i (gamma_div),
    .valid_o (ed_valid),
    .idx_o   (ed_idx),
    .flags_o (ed_flags),
    .e_o     (e)
  );

  gre_exp #(.INDEX_BITS(INDEX_BITS), .FRAC_BITS(FRAC_BITS)) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ed_valid),
    .idx_i   (ed_idx),
    .flags_i (ed_flags),
    .e_i     (e),
    .valid_o (ex_valid),
    .idx_o   (ex_idx),
    .flags_o (ex_flags),
    .power_o (power)
  );

  gre_out #(.INDEX_BITS(INDEX_BITS), .FRAC_BITS(FRAC_BITS)) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (ex_valid),
    .idx_i      (ex_idx),
    .flags_i    (ex_flags),
    .power_i    (power),
    .contrast_i (contrast_q),
    .bright_i   (bright_q),
    .valid_o    (out_valid),
    .idx_o      (result_o.index_echo),
    .oor_o      (result_o.index_out_of_range),
    .level_o    (result_o.level)
  );

  assign result_o.valid = out_valid;

endmodule

[hdl/gre_xdiv.sv]
// Pipelined restoring divider forming x = floor(i * 65536 / (N-1)), one quotient bit a stage.
module gre_xdiv #(
  parameter int INDEX_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [INDEX_BITS-1:0]           idx_i,
  input  gre_pkg::flags_t                 flags_i,
  input  logic [gre_pkg::ENTRIES_W-1:0]   last_i,
  output logic                            valid_o,
  output logic [INDEX_BITS-1:0]           idx_o,
  output gre_pkg::flags_t                 flags_o,
  output logic [gre_pkg::X_W-1:0]         x_o
);

  localparam int Steps = gre_pkg::X_W;
  localparam int RW    = gre_pkg::ENTRIES_W + 1;

  logic                  v_q   [Steps];
  logic [INDEX_BITS-1:0] idx_q [Steps];
  gre_pkg::flags_t       fl_q  [Steps];
  logic [RW-1:0]         rem_q [Steps];
  logic [Steps-1:0]      quo_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_st
    logic                  v_in;
    logic [INDEX_BITS-1:0] idx_in;
    gre_pkg::flags_t       fl_in;
    logic [RW-1:0]         trial;
    logic [Steps-1:0]      quo_in;
    logic                  ge;

    if (s == 0) begin : g_head
      // The first step handles the integer bit: the index is never above N-1 when in range.
      assign v_in   = valid_i;
      assign idx_in = idx_i;
      assign fl_in  = flags_i;
      assign trial  = RW'(idx_i);
      assign quo_in = '0;
    end else begin : g_body
      assign v_in   = v_q[s-1];
      assign idx_in = idx_q[s-1];
      assign fl_in  = fl_q[s-1];
      assign trial  = {rem_q[s-1][RW-2:0], 1'b0};
      assign quo_in = quo_q[s-1];
    end

    assign ge = trial >= RW'(last_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        idx_q[s] <= idx_in;
        fl_q[s]  <= fl_in;
        rem_q[s] <= ge ? trial - RW'(last_i) : trial;
        quo_q[s] <= {quo_in[Steps-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign idx_o   = idx_q[Steps-1];
  assign flags_o = fl_q[Steps-1];
  assign x_o     = quo_q[Steps-1];

endmodule

[hdl/gre_log.sv]
// Pipelined -log2 of a Q1.16 value: leading-one stage, then one mantissa squaring a stage.
module gre_log #(
  parameter int INDEX_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [INDEX_BITS-1:0]        idx_i,
  input  gre_pkg::flags_t              flags_i,
  input  logic [gre_pkg::X_W-1:0]      x_i,
  output logic                         valid_o,
  output logic [INDEX_BITS-1:0]        idx_o,
  output gre_pkg::flags_t              flags_o,
  output logic [gre_pkg::NL_W-1:0]     nl_o
);

  localparam int Steps = gre_pkg::LFRAC_W + 1;
  localparam int MW    = gre_pkg::MANT_W;
  localparam int FW    = gre_pkg::LFRAC_W;
  localparam int BW    = gre_pkg::MSB_W;

  logic                  v_q    [Steps];
  logic [INDEX_BITS-1:0] idx_q  [Steps];
  gre_pkg::flags_t       fl_q   [Steps];
  logic [MW-1:0]         mant_q [Steps];
  logic [BW-1:0]         msb_q  [Steps];
  logic [FW-1:0]         frac_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_st
    logic                  v_in;
    logic [INDEX_BITS-1:0] idx_in;
    gre_pkg::flags_t       fl_in;
    logic [MW-1:0]         mant_d;
    logic [BW-1:0]         msb_d;
    logic [FW-1:0]         frac_d;

    if (s == 0) begin : g_head
      // Normalize x so that its leading one lands on bit 30 (1.0 in Q.30).
      assign v_in   = valid_i;
      assign idx_in = idx_i;
      assign fl_in  = flags_i;
      always_comb begin
        msb_d = '0;
        for (int b = 1; b < gre_pkg::X_W; b++) begin
          if (x_i[b]) begin
            msb_d = BW'(b);
          end
        end
      end
      assign mant_d = MW'({{(MW - gre_pkg::X_W){1'b0}}, x_i} << (BW'(MW - 1) - msb_d));
      assign frac_d = '0;
    end else begin : g_body
      logic [2*MW-1:0] sq;
      logic [MW:0]     sh;
      assign v_in   = v_q[s-1];
      assign idx_in = idx_q[s-1];
      assign fl_in  = fl_q[s-1];
      assign sq     = mant_q[s-1] * mant_q[s-1];
      assign sh     = sq[2*MW-1:MW-1];
      // A square that reaches 2.0 yields one fraction bit and is halved.
      assign mant_d = sh[MW] ? sh[MW:1] : sh[MW-1:0];
      assign msb_d  = msb_q[s-1];
      assign frac_d = {frac_q[s-1][FW-2:0], sh[MW]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        idx_q[s]  <= idx_in;
        fl_q[s]   <= fl_in;
        mant_q[s] <= mant_d;
        msb_q[s]  <= msb_d;
        frac_q[s] <= frac_d;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign idx_o   = idx_q[Steps-1];
  assign flags_o = fl_q[Steps-1];
  assign nl_o    = {BW'(16) - msb_q[Steps-1], 16'd0} - gre_pkg::NL_W'(frac_q[Steps-1]);

endmodule

[hdl/gre_ediv.sv]
// Pipelined restoring divider forming e = floor(nl * 2^FRAC_BITS / gamma), one bit a stage.
module gre_ediv #(
  parameter int INDEX_BITS = 12,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [INDEX_BITS-1:0]                  idx_i,
  input  gre_pkg::flags_t                        flags_i,
  input  logic [gre_pkg::NL_W-1:0]               nl_i,
  input  logic [gre_pkg::SET_W-1:0]              gamma_i,
  output logic                                   valid_o,
  output logic [INDEX_BITS-1:0]                  idx_o,
  output gre_pkg::flags_t                        flags_o,
  output logic [gre_pkg::NL_W+FRAC_BITS-1:0]     e_o
);

  localparam int DW = gre_pkg::NL_W + FRAC_BITS;
  localparam int GW = gre_pkg::SET_W;

  logic                  v_q   [DW];
  logic [INDEX_BITS-1:0] idx_q [DW];
  gre_pkg::flags_t       fl_q  [DW];
  logic [GW-1:0]         rem_q [DW];
  logic [DW-1:0]         dv_q  [DW];
  logic [DW-1:0]         quo_q [DW];

  for (genvar s = 0; s < DW; s++) begin : g_st
    logic                  v_in;
    logic [INDEX_BITS-1:0] idx_in;
    gre_pkg::flags_t       fl_in;
    logic [GW-1:0]         rem_in;
    logic [DW-1:0]         dv_in;
    logic [DW-1:0]         quo_in;
    logic [GW:0]           trial;
    logic                  ge;

    if (s == 0) begin : g_head
      assign v_in   = valid_i;
      assign idx_in = idx_i;
      assign fl_in  = flags_i;
      assign rem_in = '0;
      assign dv_in  = DW'(nl_i) << FRAC_BITS;
      assign quo_in = '0;
    end else begin : g_body
      assign v_in   = v_q[s-1];
      assign idx_in = idx_q[s-1];
      assign fl_in  = fl_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dv_in  = dv_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = {rem_in, dv_in[DW-1]};
    assign ge    = trial >= {1'b0, gamma_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        idx_q[s] <= idx_in;
        fl_q[s]  <= fl_in;
        rem_q[s] <= GW'(ge ? trial - {1'b0, gamma_i} : trial);
        dv_q[s]  <= dv_in << 1;
        quo_q[s] <= {quo_in[DW-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[DW-1];
  assign idx_o   = idx_q[DW-1];
  assign flags_o = fl_q[DW-1];
  assign e_o     = quo_q[DW-1];

endmodule

[hdl/gre_exp.sv]
// Pipelined 2^-e: one root-table multiply per fraction bit, then the integer shift.
module gre_exp #(
  parameter int INDEX_BITS = 12,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [INDEX_BITS-1:0]               idx_i,
  input  gre_pkg::flags_t                     flags_i,
  input  logic [gre_pkg::NL_W+FRAC_BITS-1:0]  e_i,
  output logic                                valid_o,
  output logic [INDEX_BITS-1:0]               idx_o,
  output gre_pkg::flags_t                     flags_o,
  output logic [gre_pkg::POW_W-1:0]           power_o
);

  localparam int EW    = gre_pkg::NL_W + FRAC_BITS;
  localparam int FW    = gre_pkg::LFRAC_W;
  localparam int AW    = gre_pkg::MANT_W;
  localparam int RW    = gre_pkg::ROOT_W;
  localparam int BW    = gre_pkg::MSB_W;
  localparam int Steps = FW + 1;

  logic                  v_q    [Steps];
  logic [INDEX_BITS-1:0] idx_q  [Steps];
  gre_pkg::flags_t       fl_q   [Steps];
  logic [AW-1:0]         acc_q  [FW];
  logic [FW-1:0]         fp_q   [FW];
  logic [BW-1:0]         sh_q   [FW];
  logic                  big_q  [FW];
  logic [gre_pkg::POW_W-1:0] power_q;

  for (genvar s = 0; s < FW; s++) begin : g_st
    localparam logic [RW-1:0] Root = gre_pkg::root_q30(s + 1);
    logic                  v_in;
    logic [INDEX_BITS-1:0] idx_in;
    gre_pkg::flags_t       fl_in;
    logic [AW-1:0]         acc_in;
    logic [FW-1:0]         fp_in;
    logic [BW-1:0]         sh_in;
    logic                  big_in;
    logic [AW+RW-1:0]      prod;

    if (s == 0) begin : g_head
      // Integer parts of 31 or more flush the result to zero.
      assign v_in   = valid_i;
      assign idx_in = idx_i;
      assign fl_in  = flags_i;
      assign acc_in = AW'(1) << (AW - 1);
      assign fp_in  = e_i[FW-1:0];
      assign sh_in  = e_i[BW-1+FW:FW];
      assign big_in = e_i[EW-1:FW] >= (EW-FW)'(31);
    end else begin : g_body
      assign v_in   = v_q[s-1];
      assign idx_in = idx_q[s-1];
      assign fl_in  = fl_q[s-1];
      assign acc_in = acc_q[s-1];
      assign fp_in  = fp_q[s-1];
      assign sh_in  = sh_q[s-1];
      assign big_in = big_q[s-1];
    end

    assign prod = acc_in * Root;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        idx_q[s] <= idx_in;
        fl_q[s]  <= fl_in;
        acc_q[s] <= fp_in[FW-1-s] ? prod[AW+RW-1:AW-1] : acc_in;
        fp_q[s]  <= fp_in;
        sh_q[s]  <= sh_in;
        big_q[s] <= big_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[Steps-1] <= 1'b0;
    end else if (en_i) begin
      v_q[Steps-1] <= v_q[FW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q[Steps-1] <= idx_q[FW-1];
      fl_q[Steps-1]  <= fl_q[FW-1];
      if (big_q[FW-1] || fl_q[FW-1].zero) begin
        power_q <= '0;
      end else begin
        power_q <= gre_pkg::POW_W'((acc_q[FW-1] >> sh_q[FW-1]) >> 14);
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign idx_o   = idx_q[Steps-1];
  assign flags_o = fl_q[Steps-1];
  assign power_o = power_q;

endmodule

[hdl/gre_out.sv]
// Contrast multiply, brightness offset with clamp, and scaling to a 16-bit level.
module gre_out #(
  parameter int INDEX_BITS = 12,
  parameter int FRAC_BITS  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [INDEX_BITS-1:0]         idx_i,
  input  gre_pkg::flags_t               flags_i,
  input  logic [gre_pkg::POW_W-1:0]     power_i,
  input  logic [gre_pkg::SET_W-1:0]     contrast_i,
  input  logic [gre_pkg::SET_W-1:0]     bright_i,
  output logic                          valid_o,
  output logic [INDEX_BITS-1:0]         idx_o,
  output logic                          oor_o,
  output logic [15:0]                   level_o
);

  localparam int PW = gre_pkg::SET_W + gre_pkg::POW_W;
  localparam int SW = PW + 2;
  localparam int YW = FRAC_BITS + 17;

  logic                  va_q, vb_q, vc_q;
  logic [INDEX_BITS-1:0] idxa_q, idxb_q, idxc_q;
  gre_pkg::flags_t       fla_q, flb_q;
  logic                  oorc_q;
  logic [PW-1:0]         prod_q;
  logic [YW-1:0]         y_q;
  logic [15:0]           level_q;

  logic signed [SW-1:0]  offset;
  logic signed [SW-1:0]  ysum;
  logic signed [SW-1:0]  top;
  logic [YW-1:0]         y_d;
  logic [YW+15:0]        scaled;

  assign offset = $signed(SW'(bright_i)) - $signed(SW'(1) << FRAC_BITS);
  assign ysum   = $signed(SW'(prod_q)) + (offset <<< 16);
  assign top    = $signed(SW'(1) << (FRAC_BITS + 16));

  always_comb begin
    if (ysum < 0) begin
      y_d = '0;
    end else if (ysum > top) begin
      y_d = YW'(top);
    end else begin
      y_d = YW'(ysum);
    end
  end

  // y * 65535 written as a shift and a subtract.
  assign scaled = {y_q, 16'd0} - (YW+16)'(y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idxa_q  <= idx_i;
      fla_q   <= flags_i;
      prod_q  <= contrast_i * power_i;
      idxb_q  <= idxa_q;
      flb_q   <= fla_q;
      y_q     <= y_d;
      idxc_q  <= idxb_q;
      oorc_q  <= flb_q.oor;
      level_q <= flb_q.oor ? 16'd0 : scaled[FRAC_BITS+31:FRAC_BITS+16];
    end
  end

  assign valid_o = vc_q;
  assign idx_o   = idxc_q;
  assign oor_o   = oorc_q;
  assign level_o = level_q;

endmodule

[tb/gamma_ramp_entry_generator_tb.sv]
// Self-checking testbench for the gamma ramp entry generator: directed table plus random entries.
module gamma_ramp_entry_generator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_BITS = 12;
  localparam int FRAC_BITS  = 12;
  // Wait used by drain_pipe after the last expected result has come back.
  localparam int PIPE_LAT   = 75 + FRAC_BITS + 10;

  typedef struct packed {
    logic [15:0]           level;
    logic [INDEX_BITS-1:0] index;
    logic                  oor;
  } ramp_result_t;

  // One row of the directed table. A row with has_level set carries a level that can be
  // read straight off the definition; other rows are checked only against the predictor.
  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic                  has_level;
    logic [15:0]           level;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [gre_pkg::REG_IDX_W-1:0] cfg_idx_i;
  logic [gre_pkg::SET_W-1:0]     cfg_data_i;

  gre_in_if  #(.INDEX_BITS(INDEX_BITS)) entry_if ();
  gre_out_if #(.INDEX_BITS(INDEX_BITS)) result_if ();

  gamma_ramp_entry_generator #(
    .INDEX_BITS(INDEX_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .entry_i   (entry_if.sink),
    .result_o  (result_if.source)
  );

  // Shadow copy of the configuration registers, updated with every write.
  logic [gre_pkg::ENTRIES_W-1:0] shadow_entries;
  logic [gre_pkg::SET_W-1:0]     shadow_contrast;
  logic [gre_pkg::SET_W-1:0]     shadow_brightness;
  logic [gre_pkg::SET_W-1:0]     shadow_gamma;

  logic [63:0]  root_table [0:16];
  ramp_result_t pending_levels[$];
  // Directed levels that go with the front of pending_levels; -1 means none.
  int           typed_levels[$];
  int           fail_count;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Integer square root of a 64-bit value, used to build the root table.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 64'd0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // -log2(x / 65536) in Q.16 for x in 1..65536.
  function automatic logic [63:0] neg_log2(input logic [63:0] x);
    int unsigned msb;
    logic [63:0] mant;
    logic [63:0] frac;
    msb  = 0;
    frac = 64'd0;
    while (msb < 16 && (x >> (msb + 1)) != 0) msb++;
    mant = x << (30 - msb);
    for (int k = 1; k <= 16; k++) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac = frac | (64'd1 << (16 - k));
      end
    end
    return 64'(16 - msb) * 64'd65536 - frac;
  endfunction

  // 2^-e for e in Q.16, returned in Q.16.
  function automatic logic [63:0] exp2_neg(input logic [63:0] e);
    logic [63:0] acc;
    if ((e >> 16) >= 31) return 64'd0;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      if (e[16-k]) acc = (acc * root_table[k]) >> 30;
    end
    acc = acc >> (e >> 16);
    return acc >> 14;
  endfunction

  // Expected result for one entry index under the current shadow configuration.
  function automatic ramp_result_t ramp_entry(input logic [INDEX_BITS-1:0] idx);
    ramp_result_t r;
    logic [63:0]  last;
    logic [63:0]  divisor;
    logic [63:0]  power;
    longint       y;
    longint       top;
    last    = (shadow_entries < 2) ? 64'd1 : 64'(shadow_entries) - 1;
    divisor = (shadow_gamma == 0) ? 64'd1 : 64'(shadow_gamma);
    top     = longint'(1) << (FRAC_BITS + 16);
    power   = 64'd0;
    r.index = idx;
    if (64'(idx) > last) begin
      r.level = 16'd0;
      r.oor   = 1'b1;
      return r;
    end
    if (idx != 0) begin
      power = exp2_neg((neg_log2((64'(idx) << 16) / last) << FRAC_BITS) / divisor);
    end
    y = longint'(shadow_contrast) * longint'(power)
        + (longint'(shadow_brightness) - (longint'(1) << FRAC_BITS)) * 65536;
    if (y < 0) y = 0;
    if (y > top) y = top;
    r.level = 16'((64'(y) * 64'd65535) >> (FRAC_BITS + 16));
    r.oor   = 1'b0;
    return r;
  endfunction

  // Writes one register while the block is idle and mirrors it in the shadow copy.
  task automatic write_reg(input logic [gre_pkg::REG_IDX_W-1:0] idx,
                           input logic [gre_pkg::SET_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      gre_pkg::REG_RAMP_ENTRIES:     shadow_entries    = val[gre_pkg::ENTRIES_W-1:0];
      gre_pkg::REG_CONTRAST_GAIN:    shadow_contrast   = val;
      gre_pkg::REG_BRIGHTNESS_LEVEL: shadow_brightness = val;
      gre_pkg::REG_GAMMA_VALUE:      shadow_gamma      = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [gre_pkg::SET_W-1:0] n,
                         input logic [gre_pkg::SET_W-1:0] c,
                         input logic [gre_pkg::SET_W-1:0] b,
                         input logic [gre_pkg::SET_W-1:0] g);
    write_reg(gre_pkg::REG_RAMP_ENTRIES, n);
    write_reg(gre_pkg::REG_CONTRAST_GAIN, c);
    write_reg(gre_pkg::REG_BRIGHTNESS_LEVEL, b);
    write_reg(gre_pkg::REG_GAMMA_VALUE, g);
  endtask

  // Waits until every expected level has come back, then lets the pipeline drain.
  task automatic drain_pipe();
    entry_if.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  // Presents one entry after a random gap and holds it until the transfer happens.
  // The expectation is queued at the transfer edge, ahead of any possible result.
  // With no gap the entry follows the previous one back to back and valid stays high.
  task automatic send_entry(input logic [INDEX_BITS-1:0] idx, input int typed);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      entry_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    entry_if.valid       <= 1'b1;
    entry_if.entry_index <= idx;
    do @(posedge clk_i); while (!entry_if.ready);
    pending_levels.push_back(ramp_entry(idx));
    typed_levels.push_back(typed);
  endtask

  // Random index: mostly inside the ramp, with edges and out-of-range noise.
  function automatic logic [INDEX_BITS-1:0] pick_index();
    int last;
    last = (shadow_entries < 2) ? 1 : int'(shadow_entries) - 1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return INDEX_BITS'(last > 4095 ? 4095 : last);
      2: return INDEX_BITS'($urandom_range(0, 4095));
      default: return INDEX_BITS'($urandom_range(0, last > 4095 ? 4095 : last));
    endcase
  endfunction

  // The receiver stalls a random number of cycles before each result, with bursts of none.
  initial begin
    int stall;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  // Compares each result transfer with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    ramp_result_t exp_r;
    int           typed;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result level=%0d index=%0d", $realtime,
                 result_if.level, result_if.index_echo);
        fail_count++;
      end else begin
        exp_r = pending_levels.pop_front();
        typed = typed_levels.pop_front();
        if (result_if.level !== exp_r.level) begin
          $display("%0t: level mismatch, expected %0d actual %0d", $realtime,
                   exp_r.level, result_if.level);
          fail_count++;
        end
        if (typed >= 0 && result_if.level !== 16'(typed)) begin
          $display("%0t: directed level mismatch, expected %0d actual %0d", $realtime,
                   typed, result_if.level);
          fail_count++;
        end
        if (result_if.index_echo !== exp_r.index) begin
          $display("%0t: index mismatch, expected %0d actual %0d", $realtime,
                   exp_r.index, result_if.index_echo);
          fail_count++;
        end
        if (result_if.index_out_of_range !== exp_r.oor) begin
          $display("%0t: range flag mismatch, expected %0b actual %0b", $realtime,
                   exp_r.oor, result_if.index_out_of_range);
          fail_count++;
        end
      end
    end
  end

  // Directed table, first under reset settings (N = 256, unity everything).
  dir_row_t reset_rows[8] = '{
    '{12'd0,    1'b1, 16'd0},
    '{12'd255,  1'b1, 16'd65535},
    '{12'd256,  1'b1, 16'd0},
    '{12'd4095, 1'b1, 16'd0},
    '{12'd1,    1'b0, 16'd0},
    '{12'd128,  1'b0, 16'd0},
    '{12'd2730, 1'b1, 16'd0},
    '{12'd1365, 1'b1, 16'd0}
  };

  initial begin
    int idx_n;
    logic [gre_pkg::SET_W-1:0] n_pick;
    fail_count           = 0;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = gre_pkg::REG_RAMP_ENTRIES;
    cfg_data_i           = '0;
    entry_if.valid       = 1'b0;
    entry_if.entry_index = '0;
    root_table[0] = 64'd1 << 29;
    for (int k = 1; k <= 16; k++) root_table[k] = isqrt64(root_table[k-1] << 30);
    shadow_entries    = 13'd256;
    shadow_contrast   = 16'd4096;
    shadow_brightness = 16'd4096;
    shadow_gamma      = 16'd4096;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (reset_rows[r]) begin
      send_entry(reset_rows[r].index,
                 reset_rows[r].has_level ? int'(reset_rows[r].level) : -1);
    end
    drain_pipe();

    // A 4096-entry ramp and zero contrast with full brightness: every in-range level saturates.
    set_all(16'd4096, 16'd0, 16'd8192, 16'd1);
    send_entry(12'd0, 65535);
    send_entry(12'd4095, 65535);
    drain_pipe();

    // Shortest ramp, zero gamma, maximum contrast, zero brightness.
    set_all(16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_entry(12'd0, 0);
    send_entry(12'd1, 65535);
    send_entry(12'd2, 0);
    drain_pipe();

    // A ramp of one entry is treated as two; maximum gamma and brightness.
    set_all(16'd1, 16'd4096, 16'hFFFF, 16'hFFFF);
    send_entry(12'd1, 65535);
    send_entry(12'd3, 0);
    drain_pipe();

    // Ramp length with the top register bit set; ordinary gamma 2.2.
    set_all(16'h1FFF, 16'd4096, 16'd4096, 16'd9011);
    send_entry(12'd1, -1);
    send_entry(12'd4095, -1);
    send_entry(12'd2048, -1);
    drain_pipe();

    // Random phases, each with a fresh setting, mostly small ramps.
    for (int ph = 0; ph < 13; ph++) begin
      case ($urandom_range(0, 3))
        0:       n_pick = gre_pkg::SET_W'($urandom_range(0, 8191));
        1:       n_pick = 16'd4096;
        default: n_pick = gre_pkg::SET_W'($urandom_range(2, 300));
      endcase
      set_all(n_pick,
              ($urandom_range(0, 3) == 0) ? gre_pkg::SET_W'($urandom)
                                          : gre_pkg::SET_W'($urandom_range(2048, 8192)),
              ($urandom_range(0, 3) == 0) ? gre_pkg::SET_W'($urandom)
                                          : gre_pkg::SET_W'($urandom_range(2048, 6144)),
              ($urandom_range(0, 4) == 0) ? gre_pkg::SET_W'($urandom)
                                          : gre_pkg::SET_W'($urandom_range(1024, 12288)));
      for (idx_n = 0; idx_n < 50; idx_n++) begin
        send_entry(pick_index(), -1);
        // Once in the run the sender holds off until everything has come back.
        if (ph == 3 && idx_n == 25) begin
          entry_if.valid <= 1'b0;
          while (pending_levels.size() != 0) @(posedge clk_i);
        end
      end
      drain_pipe();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
hdl/gre_pkg.sv
hdl/gre_in_if.sv
hdl/gre_out_if.sv
hdl/gre_xdiv.sv
hdl/gre_log.sv
hdl/gre_ediv.sv
hdl/gre_exp.sv
hdl/gre_out.sv
hdl/gamma_ramp_entry_generator.sv
tb/gamma_ramp_entry_generator_tb.sv
